// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define HSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HSC_ASSERT(lbl, prop, msg)
`define HSC_ASSERT_IMPL(lbl, ante, cons, msg)
`define HSC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/hsc_pkg.sv =====
`default_nettype none

package hsc_pkg;

    localparam int TIMER_W   = 32;
    localparam int POLE_W    = 8;
    localparam int FS_W      = 12;
    localparam int DUTY_W    = 7;
    localparam int RPM_W     = 16;
    localparam int PHASE_W   = 2;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;

    // Dividend width covers the largest throttle product, 4095 * 100.
    localparam int DIV_NW    = FS_W + 7;
    localparam int DIV_DW    = TIMER_W;
    localparam int DIV_CNT_W = $clog2(DIV_NW + 1);

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [RPM_W-1:0]   RPM_NUMERATOR = RPM_W'(60000);
    localparam logic [TIMER_W-1:0] STALE_TICKS   = TIMER_W'(1000);
    localparam logic [DUTY_W-1:0]  DUTY_MAX      = DUTY_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_POLES      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE      = CFG_IDX_W'(2);

    typedef enum logic [MODE_W-1:0] {
        MODE_HALL_EDGE   = 2'd0,
        MODE_RECOMMUTATE = 2'd1,
        MODE_TICK        = 2'd2,
        MODE_THROTTLE    = 2'd3
    } hsc_mode_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_NONE = 2'd0,
        PH_A    = 2'd1,
        PH_B    = 2'd2,
        PH_C    = 2'd3
    } hsc_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUTY_GO,
        ST_DUTY_WAIT,
        ST_RPM_GO,
        ST_RPM_WAIT,
        ST_DONE
    } hsc_state_t;

    // Hall code is {a, b, c}.
    function automatic hsc_phase_t phase_high(input logic [2:0] code);
        hsc_phase_t ph;
        unique case (code)
            3'b001:  ph = PH_C;
            3'b010:  ph = PH_B;
            3'b011:  ph = PH_C;
            3'b100:  ph = PH_A;
            3'b101:  ph = PH_A;
            3'b110:  ph = PH_B;
            default: ph = PH_NONE;
        endcase
        return ph;
    endfunction

    function automatic hsc_phase_t phase_low(input logic [2:0] code);
        hsc_phase_t ph;
        unique case (code)
            3'b001:  ph = PH_B;
            3'b010:  ph = PH_A;
            3'b011:  ph = PH_A;
            3'b100:  ph = PH_C;
            3'b101:  ph = PH_B;
            3'b110:  ph = PH_C;
            default: ph = PH_NONE;
        endcase
        return ph;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hsc_divider.sv =====
`default_nettype none

module hsc_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [hsc_pkg::DIV_NW-1:0] dividend,
    input  wire logic [hsc_pkg::DIV_DW-1:0] divisor,
    output logic                           done,
    output logic [hsc_pkg::DIV_NW-1:0]     quotient
);
    import hsc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DW-1:0]    rem_reg, rem_next;
    logic [DIV_NW-1:0]    quo_reg, quo_next;
    logic [DIV_DW-1:0]    dsr_reg, dsr_next;
    logic [DIV_DW:0]      trial;
    logic                 fits;

    // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NW);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_DW'(trial - {1'b0, dsr_reg}) : trial[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`include "assert_macros.svh"

    `HSC_ASSERT_IMPL(a_div_done_idle, done_reg, !busy_reg, "divider done while still busy")
    `HSC_ASSERT_IMPL(a_div_cnt_busy, busy_reg, cnt_reg != '0, "divider busy with empty count")
    `HSC_ASSERT_NEXT(a_div_start_busy, start, busy_reg, "divider did not start")

endmodule

`default_nettype wire

// ===== rtl/hall_six_step_commutator_unit.sv =====
`default_nettype none

// Six-step Hall commutator. Every input transaction yields exactly one output
// transaction carrying the drive pair, the duty, the Hall error flag, the pole index
// and the rpm. The block takes one transaction at a time and is not ready until the
// result has been handed to the output register. A Hall edge, recommutate request or
// tick runs only the rpm division (60000 / rotation time), a throttle sample first
// the duty division (sample * 100 / full scale) and then the rpm division; both are
// computed on one shared restoring divider that retires one quotient bit of 19
// per cycle. The output register lets the next transaction be accepted while the
// previous result still waits for the downstream side. Configuration is written
// through cfg_we, cfg_index and cfg_data and must only change while the block is idle.
module hall_six_step_commutator_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // Bits from lowest: hall_a, hall_b, hall_c, throttle_sample[11:0], one zero pad.
    input  wire logic [hsc_pkg::IN_DATA_W-1:0]      s_tdata,
    // Bits from lowest: mode[1:0].
    input  wire logic [hsc_pkg::MODE_W-1:0]         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // Bits from lowest: high_phase[1:0], low_phase[1:0], duty_percent[6:0],
    // hall_error, pole_index[7:0], rpm[15:0], four zero pads.
    output logic [hsc_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [hsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hsc_pkg::CFG_W-1:0]          cfg_data
);
    import hsc_pkg::*;

    hsc_state_t state_reg, state_next;

    logic [POLE_W-1:0]  poles_reg;
    logic [FS_W-1:0]    full_scale_reg;
    logic               brake_reg;

    logic [TIMER_W-1:0] tick_count_reg;
    logic [TIMER_W-1:0] rotation_start_reg;
    logic [TIMER_W-1:0] rotation_time_reg;
    logic [POLE_W-1:0]  pole_counter_reg;
    logic [DUTY_W-1:0]  duty_reg;
    hsc_phase_t         drive_high_reg;
    hsc_phase_t         drive_low_reg;

    logic               err_reg;
    logic [POLE_W-1:0]  pole_index_reg;
    logic [RPM_W-1:0]   rpm_reg;
    logic [DIV_NW-1:0]  product_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic               in_accept;
    logic [2:0]         hall_code;
    hsc_mode_t          mode;
    logic [FS_W-1:0]    sample;
    logic               code_bad;
    logic [POLE_W:0]    pole_next;
    logic               pole_wrap;
    logic [TIMER_W-1:0] since_wrap;
    logic               rpm_zero;

    logic               div_start;
    logic               div_sel_duty;
    logic               load_result;
    logic               out_free;
    logic [DIV_NW-1:0]  div_dividend;
    logic [DIV_DW-1:0]  div_divisor;
    logic               div_done;
    logic [DIV_NW-1:0]  div_quotient;

    assign mode      = hsc_mode_t'(s_tuser);
    assign hall_code = {s_tdata[0], s_tdata[1], s_tdata[2]};
    assign sample    = s_tdata[FS_W+2:3];
    assign in_accept = s_tvalid && s_tready;
    assign code_bad  = (hall_code == 3'b000) || (hall_code == 3'b111);
    assign pole_next = {1'b0, pole_counter_reg} + (POLE_W+1)'(1);
    assign pole_wrap = (pole_next >= {1'b0, poles_reg});
    assign out_free  = !out_valid_reg || m_tready;

    assign since_wrap = tick_count_reg - rotation_start_reg;
    assign rpm_zero   = (rotation_time_reg == '0) || (since_wrap > STALE_TICKS);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = (mode == MODE_THROTTLE) ? ST_DUTY_GO : ST_RPM_GO;
            ST_DUTY_GO:
                state_next = ST_DUTY_WAIT;
            ST_DUTY_WAIT:
                if (div_done)
                    state_next = ST_RPM_GO;
            ST_RPM_GO:
                state_next = ST_RPM_WAIT;
            ST_RPM_WAIT:
                if (div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = (state_reg == ST_IDLE);
        div_start    = (state_reg == ST_DUTY_GO) || (state_reg == ST_RPM_GO);
        div_sel_duty = (state_reg == ST_DUTY_GO);
        load_result  = (state_reg == ST_DONE) && out_free;
    end

    // A zero full scale divides by one.
    assign div_dividend = div_sel_duty ? product_reg : DIV_NW'(RPM_NUMERATOR);
    assign div_divisor  = div_sel_duty
                        ? ((full_scale_reg == '0) ? DIV_DW'(1) : DIV_DW'(full_scale_reg))
                        : rotation_time_reg;

    hsc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            poles_reg          <= POLE_W'(8);
            full_scale_reg     <= FS_W'(4095);
            brake_reg          <= 1'b0;
            tick_count_reg     <= '0;
            rotation_start_reg <= '0;
            rotation_time_reg  <= '0;
            pole_counter_reg   <= '0;
            duty_reg           <= '0;
            drive_high_reg     <= PH_NONE;
            drive_low_reg      <= PH_NONE;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POLES:      poles_reg <= cfg_data[POLE_W-1:0];
                    CFG_FULL_SCALE: full_scale_reg <= cfg_data[FS_W-1:0];
                    CFG_BRAKE:      brake_reg <= cfg_data[0];
                    default:        ;
                endcase
            end

            if (in_accept)
            begin
                if ((mode == MODE_HALL_EDGE) || (mode == MODE_RECOMMUTATE))
                begin
                    if (code_bad || brake_reg)
                    begin
                        drive_high_reg <= PH_NONE;
                        drive_low_reg  <= PH_NONE;
                    end
                    else
                    begin
                        drive_high_reg <= phase_high(hall_code);
                        drive_low_reg  <= phase_low(hall_code);
                    end
                    if (!code_bad && (mode == MODE_HALL_EDGE))
                    begin
                        if (pole_wrap)
                        begin
                            pole_counter_reg   <= '0;
                            rotation_time_reg  <= since_wrap;
                            rotation_start_reg <= tick_count_reg;
                        end
                        else
                            pole_counter_reg <= pole_next[POLE_W-1:0];
                    end
                end
                else if (mode == MODE_TICK)
                    tick_count_reg <= tick_count_reg + TIMER_W'(1);
            end

            if ((state_reg == ST_DUTY_WAIT) && div_done)
                duty_reg <= (div_quotient > DIV_NW'(DUTY_MAX))
                          ? DUTY_MAX : div_quotient[DUTY_W-1:0];

            if (load_result)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            err_reg        <= ((mode == MODE_HALL_EDGE) || (mode == MODE_RECOMMUTATE)) && code_bad;
            pole_index_reg <= ((mode == MODE_HALL_EDGE) && !code_bad) ? pole_counter_reg : '0;
            product_reg    <= DIV_NW'({sample, 6'b0}) + DIV_NW'({sample, 5'b0})
                            + DIV_NW'({sample, 2'b0});
        end
        if ((state_reg == ST_RPM_WAIT) && div_done)
            rpm_reg <= rpm_zero ? '0 : div_quotient[RPM_W-1:0];
        if (load_result)
            out_data_reg <= OUT_DATA_W'({rpm_reg, pole_index_reg, err_reg, duty_reg,
                                         drive_low_reg, drive_high_reg});
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`include "assert_macros.svh"

    `HSC_ASSERT(a_duty_range, duty_reg <= DUTY_MAX, "duty above one hundred percent")
    `HSC_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_tready,
                     "ready right after accepting a transaction")
    `HSC_ASSERT_IMPL(a_error_no_drive, m_tvalid && m_tdata[11],
                     m_tdata[3:0] == 4'b0000, "phase driven on a Hall error")
    `HSC_ASSERT_IMPL(a_pole_counter_range, pole_counter_reg != '0,
                     pole_counter_reg <= POLE_W'(254), "pole counter out of range")

endmodule

`default_nettype wire
